/* rtl/assert_macros.svh */
// Assertion helpers for the RTL; lsf_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is high.
`define LSF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lsf_pkg.sv */
package lsf_pkg;

  localparam int HOST_W      = 8;
  localparam int PORT_W      = 3;
  localparam int MASK_BITS   = 8;
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] PORTS_RESET = 4'd8;

  typedef struct packed {
    logic [HOST_W-1:0]    src;
    logic [HOST_W-1:0]    dst;
    logic [PORT_W-1:0]    arr;
    logic [MASK_BITS-1:0] flood_mask;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    logic [MASK_BITS-1:0] send_mask;
    logic                 flooded;
    logic                 learned_new;
    logic                 table_full;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* rtl/learning_switch_forwarding.sv */
// Channel   Direction  Handshake                    Payload
// header    in         start, busy                  source_host, dest_host, arrival_port
// result    out        done (one-cycle strobe)      send_mask, flooded, learned_new, table_full
// config    in         cfg_valid, cfg_ready         cfg_data (ports_in_use)
//
// A header is taken when start is high and busy is low. It waits in a two-entry
// queue until the back end is idle. The back end takes one header at a time and
// reads the learned entries one per cycle, then learns the source and registers
// the result together with done. Synchronous reset empties the table at once
// through its fill count; busy is high and cfg_ready low while reset is held.
// The result stays on its ports for the single cycle that done is high; the
// receiver cannot stall it.
module learning_switch_forwarding #(
  parameter int TABLE_DEPTH = 128,
  parameter int PORT_COUNT  = 8,
  parameter int HOST_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lsf_pkg::HOST_W-1:0]     source_host,
  input  logic [lsf_pkg::HOST_W-1:0]     dest_host,
  input  logic [lsf_pkg::PORT_W-1:0]     arrival_port,
  output logic                           done,
  output logic [lsf_pkg::MASK_BITS-1:0]  send_mask,
  output logic                           flooded,
  output logic                           learned_new,
  output logic                           table_full,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsf_pkg::CFG_W-1:0]      cfg_data
);

  lsf_pkg::queue_out_t q_link;
  lsf_pkg::result_t    result;
  logic                pop;

  // The front end takes each header transfer, works out its flood set from
  // the port count and queues it.
  lsf_front #(
    .PORT_COUNT(PORT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .source_host  (source_host),
    .dest_host    (dest_host),
    .arrival_port (arrival_port),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pop          (pop),
    .q_out        (q_link)
  );

  // The back end scans the table for the source and destination together,
  // learns the source if it is new and there is room, then builds the mask.
  lsf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HOST_BITS   (HOST_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_link),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  assign send_mask   = result.send_mask;
  assign flooded     = result.flooded;
  assign learned_new = result.learned_new;
  assign table_full  = result.table_full;

endmodule

/* rtl/lsf_front.sv */
module lsf_front #(
  parameter int PORT_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [lsf_pkg::HOST_W-1:0]  source_host,
  input  logic [lsf_pkg::HOST_W-1:0]  dest_host,
  input  logic [lsf_pkg::PORT_W-1:0]  arrival_port,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lsf_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        pop,
  output lsf_pkg::queue_out_t         q_out
);

  localparam int QW = (lsf_pkg::QUEUE_DEPTH > 1) ? $clog2(lsf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(lsf_pkg::QUEUE_DEPTH + 1);
  localparam int FLOOD_MAX = (PORT_COUNT < lsf_pkg::MASK_BITS) ? PORT_COUNT
                                                                : lsf_pkg::MASK_BITS;

  logic [lsf_pkg::CFG_W-1:0] ports_in_use;
  logic [lsf_pkg::CFG_W-1:0] flood_ports;
  logic [lsf_pkg::MASK_BITS-1:0] flood_mask;
  lsf_pkg::item_t q_mem [lsf_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] q_count;
  logic push;
  logic do_pop;

  // Neither channel takes a transfer while reset is held.
  assign cfg_ready = !rst;
  assign busy      = rst || (q_count == CW'(lsf_pkg::QUEUE_DEPTH));
  assign push      = start && !busy;
  assign do_pop    = pop && (q_count != '0);

  // The flood set is fixed when the header comes in. The port count is to change
  // only while the block is idle; the user must see to it, the block does not check.
  always_comb begin
    if (ports_in_use > lsf_pkg::CFG_W'(FLOOD_MAX)) begin
      flood_ports = lsf_pkg::CFG_W'(FLOOD_MAX);
    end else begin
      flood_ports = ports_in_use;
    end
    for (int k = 0; k < lsf_pkg::MASK_BITS; k++) begin
      flood_mask[k] = (lsf_pkg::CFG_W'(k) < flood_ports) &&
                      (lsf_pkg::PORT_W'(k) != arrival_port);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ports_in_use <= lsf_pkg::PORTS_RESET;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      q_count      <= '0;
    end else begin
      if (cfg_valid) begin
        ports_in_use <= cfg_data;
      end
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(lsf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QW'(lsf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        q_count <= q_count + 1'b1;
      end else if (do_pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{src: source_host, dst: dest_host, arr: arrival_port,
                         flood_mask: flood_mask};
    end
  end

  assign q_out.valid = (q_count != '0);
  assign q_out.item  = q_mem[rd_ptr];

endmodule

/* rtl/lsf_back.sv */
`include "assert_macros.svh"

module lsf_back #(
  parameter int TABLE_DEPTH = 128,
  parameter int HOST_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  lsf_pkg::queue_out_t q_in,
  output logic                pop,
  output logic                done,
  output lsf_pkg::result_t    result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_BITS = (HOST_BITS < lsf_pkg::HOST_W) ? HOST_BITS : lsf_pkg::HOST_W;

  // Entries are only ever added at the lowest free slot and never removed,
  // so the valid entries are exactly those below the fill count.
  logic [KEY_BITS-1:0]       entry_host [TABLE_DEPTH];
  logic [lsf_pkg::PORT_W-1:0] entry_port [TABLE_DEPTH];

  lsf_pkg::state_t state, state_next;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] scan_addr;
  logic          rd_pend;
  logic [KEY_BITS-1:0] host_q;
  logic [lsf_pkg::PORT_W-1:0] port_q;
  lsf_pkg::item_t cur;
  logic src_hit;
  logic dst_hit;
  logic [lsf_pkg::PORT_W-1:0] dst_port;

  logic [KEY_BITS-1:0] src_key;
  logic [KEY_BITS-1:0] dst_key;
  logic scan_more;
  logic learn;
  logic full;
  logic hit;
  logic [lsf_pkg::PORT_W-1:0] hit_port;

  assign src_key   = cur.src[KEY_BITS-1:0];
  assign dst_key   = cur.dst[KEY_BITS-1:0];
  assign scan_more = (scan_addr < fill_count);
  assign learn     = !src_hit && (fill_count != CW'(TABLE_DEPTH));
  assign full      = !src_hit && (fill_count == CW'(TABLE_DEPTH));
  assign hit       = dst_hit || (learn && (dst_key == src_key));
  assign hit_port  = dst_hit ? dst_port : cur.arr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      lsf_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          pop        = 1'b1;
          state_next = lsf_pkg::ST_SCAN;
        end
      end
      lsf_pkg::ST_SCAN: begin
        if (!scan_more && !rd_pend) begin
          state_next = lsf_pkg::ST_DONE;
        end
      end
      lsf_pkg::ST_DONE: begin
        state_next = lsf_pkg::ST_IDLE;
      end
      default: begin
        state_next = lsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      done    <= (state == lsf_pkg::ST_DONE);
      rd_pend <= (state == lsf_pkg::ST_SCAN) && scan_more;
      if (state == lsf_pkg::ST_DONE && learn) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= q_in.item;
      scan_addr <= '0;
      src_hit   <= 1'b0;
      dst_hit   <= 1'b0;
    end
    if (state == lsf_pkg::ST_SCAN) begin
      if (scan_more) begin
        host_q    <= entry_host[scan_addr[AW-1:0]];
        port_q    <= entry_port[scan_addr[AW-1:0]];
        scan_addr <= scan_addr + 1'b1;
      end
      if (rd_pend) begin
        if (host_q == src_key) begin
          src_hit <= 1'b1;
        end
        if (!dst_hit && host_q == dst_key) begin
          dst_hit  <= 1'b1;
          dst_port <= port_q;
        end
      end
    end
    if (state == lsf_pkg::ST_DONE) begin
      if (learn) begin
        entry_host[fill_count[AW-1:0]] <= src_key;
        entry_port[fill_count[AW-1:0]] <= cur.arr;
      end
      result.send_mask   <= hit ? (lsf_pkg::MASK_BITS'(1) << hit_port) : cur.flood_mask;
      result.flooded     <= !hit;
      result.learned_new <= learn;
      result.table_full  <= full;
    end
  end

  `LSF_ASSERT(a_fill_bound, clk, rst, fill_count <= CW'(TABLE_DEPTH), "fill count past depth")
  `LSF_ASSERT(a_done_follows, clk, rst, (state == lsf_pkg::ST_DONE) |=> done, "result strobe missing")
  `LSF_ASSERT(a_fill_only_done, clk, rst, (fill_count != $past(fill_count)) |-> $past(state == lsf_pkg::ST_DONE), "fill count moved outside finish")
  `LSF_ASSERT(a_learn_xor_full, clk, rst, done |-> !(result.learned_new && result.table_full), "learned and full together")

endmodule
